// ===== hw/rtl/i2crs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register slave package
// Shared types and constants for the byte-level I2C register slave.
// ----------------------------------------------------------------------------
package i2crs_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_POP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_ADDRESS  = 3'd0,
    PH_ACK_RX   = 3'd1,
    PH_DATA_RX  = 3'd2,
    PH_ACK_TX   = 3'd3,
    PH_WAIT_ACK = 3'd4,
    PH_DATA_TX  = 3'd5,
    PH_SPARE6   = 3'd6,
    PH_SPARE7   = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    DP_COMMAND = 3'd0,
    DP_DATA    = 3'd1,
    DP_COUNT   = 3'd2,
    DP_ADDRESS = 3'd3,
    DP_CHECKED = 3'd4,
    DP_SPARE5  = 3'd5,
    DP_SPARE6  = 3'd6,
    DP_SPARE7  = 3'd7
  } dphase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_CLEAR
  } fsm_e;

  localparam logic [2:0] CFG_DEV_ADDR  = 3'd0;
  localparam logic [2:0] CFG_HIGH_REG  = 3'd1;
  localparam logic [2:0] CFG_HIGH_RO   = 3'd2;
  localparam logic [2:0] CFG_HIGH_RW   = 3'd3;
  localparam logic [2:0] CFG_LOCK      = 3'd4;
  localparam logic [2:0] CFG_FIRST_CMD = 3'd5;
  localparam logic [2:0] CFG_CHK_CODE  = 3'd6;

  localparam logic [7:0] ACK_CODE = 8'h00;
  localparam logic [7:0] NAK_CODE = 8'h01;

  localparam logic [1:0] SDA_KEEP    = 2'd0;
  localparam logic [1:0] SDA_RELEASE = 2'd1;
  localparam logic [1:0] SDA_DRIVE   = 2'd2;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [6:0] high_reg;
    logic [6:0] high_ro;
    logic [6:0] high_rw;
    logic       lock;
    logic [7:0] first_cmd;
    logic [7:0] chk_code;
  } cfg_t;

endpackage

// ===== hw/rtl/i2crs_ram.sv =====
// ----------------------------------------------------------------------------
// I2C register slave RAM
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2crs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/i2crs_cfg.sv =====
// ----------------------------------------------------------------------------
// I2C register slave configuration registers
// Holds the seven configuration registers written through the config port.
// ----------------------------------------------------------------------------
module i2crs_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  output i2crs_pkg::cfg_t  cfg_o
);

  i2crs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        i2crs_pkg::CFG_DEV_ADDR:  cfg_d.dev_addr  = cfg_data_i[6:0];
        i2crs_pkg::CFG_HIGH_REG:  cfg_d.high_reg  = cfg_data_i[6:0];
        i2crs_pkg::CFG_HIGH_RO:   cfg_d.high_ro   = cfg_data_i[6:0];
        i2crs_pkg::CFG_HIGH_RW:   cfg_d.high_rw   = cfg_data_i[6:0];
        i2crs_pkg::CFG_LOCK:      cfg_d.lock      = cfg_data_i[0];
        i2crs_pkg::CFG_FIRST_CMD: cfg_d.first_cmd = cfg_data_i;
        i2crs_pkg::CFG_CHK_CODE:  cfg_d.chk_code  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dev_addr: 7'd16, high_reg: 7'd127, high_ro: 7'd15, high_rw: 7'd63,
                 lock: 1'b1, first_cmd: 8'd128, chk_code: 8'd129};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/i2c_register_slave_checked.sv =====
// ----------------------------------------------------------------------------
// I2C register slave with checked transactions
// Byte-level I2C slave with a RAM register file, command ring and checksum.
// ----------------------------------------------------------------------------
// An item is taken at an edge where start is high and busy low; its result
// strobe follows the memory read and execute steps and is registered. Busy
// stays high until that strobe, so no new item is taken before its result.
// A checked commit adds a read and a write step per buffered byte, up to 15.
// After reset a clearing pass writes zero to every register file entry in turn;
// busy stays high through it. Results cannot be stalled.
module i2c_register_slave_checked #(
  parameter int COMMAND_QUEUE_DEPTH  = 4,
  parameter int CHECKED_BUFFER_DEPTH = 16,
  parameter int REGISTER_COUNT       = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] bus_byte_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       done_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_loaded_o,
  output logic [1:0] sda_mode_o,
  output logic       ack_phase_o,
  output logic       engaged_o,
  output logic       command_valid_o,
  output logic [7:0] command_byte_o,
  output logic       queue_nonempty_o
);

  localparam int QW = $clog2(COMMAND_QUEUE_DEPTH);
  localparam int BW = $clog2(CHECKED_BUFFER_DEPTH);
  localparam int RW = $clog2(REGISTER_COUNT);

  i2crs_pkg::cfg_t cfg;

  i2crs_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );
  assign cfg_ready_o = 1'b1;

  i2crs_pkg::fsm_e st_q, st_d;
  logic [1:0] op_q, op_d;
  logic [7:0] byte_q, byte_d;
  logic [2:0] ph_q, ph_d;
  logic       eng_q, eng_d;
  logic [2:0] dp_q, dp_d;
  logic [7:0] ptr_q, ptr_d;
  logic [BW-1:0] cnt_q, cnt_d, tgt_q, tgt_d;
  logic [7:0] sum_q, sum_d;
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic [RW-1:0] clr_q, clr_d;
  logic       done_q, done_d;
  logic [7:0] tx_q, tx_d, cb_q, cb_d;
  logic       ld_q, ld_d, cv_q, cv_d;
  logic [1:0] sda_q, sda_d;

  // Register file memory.
  logic          rf_we;
  logic [RW-1:0] rf_wa, rf_ra;
  logic [7:0]    rf_wd, rf_rd;
  i2crs_ram #(.Width(8), .Depth(REGISTER_COUNT)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd),
    .raddr_i(rf_ra), .rdata_o(rf_rd)
  );

  logic          bf_we;
  logic [BW-1:0] bf_wa, bf_ra;
  logic [7:0]    bf_wd, bf_rd;
  i2crs_ram #(.Width(8), .Depth(CHECKED_BUFFER_DEPTH)) u_buf (
    .clk_i, .we_i(bf_we), .waddr_i(bf_wa), .wdata_i(bf_wd),
    .raddr_i(bf_ra), .rdata_o(bf_rd)
  );

  logic          rg_we;
  logic [QW-1:0] rg_wa, rg_ra;
  logic [7:0]    rg_wd, rg_rd;
  i2crs_ram #(.Width(8), .Depth(COMMAND_QUEUE_DEPTH)) u_ring (
    .clk_i, .we_i(rg_we), .waddr_i(rg_wa), .wdata_i(rg_wd),
    .raddr_i(rg_ra), .rdata_o(rg_rd)
  );

  function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] x);
    return ({1'b0, x} + 1'b1 >= (QW+1)'(COMMAND_QUEUE_DEPTH)) ? '0 : x + 1'b1;
  endfunction

  // Register access windows use the pointer modulo 128.
  logic [6:0] pa;
  logic       rd_ok, wr_ok;
  assign pa    = ptr_q[6:0];
  assign rd_ok = (pa <= cfg.high_reg) && ({1'b0, pa} < 8'(REGISTER_COUNT));
  assign wr_ok = rd_ok && (pa > cfg.high_ro) && !((pa > cfg.high_rw) && cfg.lock);

  logic [7:0] rdat;
  assign rdat = rd_ok ? rf_rd : 8'h00;

  always_comb begin
    st_d = st_q; op_d = op_q; byte_d = byte_q;
    ph_d = ph_q; eng_d = eng_q; dp_d = dp_q; ptr_d = ptr_q;
    cnt_d = cnt_q; tgt_d = tgt_q; sum_d = sum_q;
    head_d = head_q; tail_d = tail_q; clr_d = clr_q;
    done_d = 1'b0; tx_d = tx_q; cb_d = cb_q; ld_d = ld_q; cv_d = cv_q; sda_d = sda_q;
    rf_we = 1'b0; rf_wa = pa[RW-1:0]; rf_wd = byte_q; rf_ra = pa[RW-1:0];
    bf_we = 1'b0; bf_wa = cnt_q; bf_wd = byte_q; bf_ra = cnt_q;
    rg_we = 1'b0; rg_wa = ring_next(head_q); rg_wd = byte_q; rg_ra = ring_next(tail_q);
    busy = (st_q != i2crs_pkg::ST_IDLE);

    case (st_q)
      i2crs_pkg::ST_CLEAR: begin
        rf_we = 1'b1; rf_wa = clr_q; rf_wd = 8'h00;
        clr_d = clr_q + 1'b1;
        if ({1'b0, clr_q} == (RW+1)'(REGISTER_COUNT - 1)) st_d = i2crs_pkg::ST_IDLE;
      end
      i2crs_pkg::ST_IDLE: begin
        if (start) begin
          op_d = operation_i; byte_d = bus_byte_i;
          st_d = i2crs_pkg::ST_READ;
        end
      end
      i2crs_pkg::ST_READ: begin
        // Memory reads at the pointer, ring tail and buffer are in flight.
        st_d = i2crs_pkg::ST_EXEC;
      end
      i2crs_pkg::ST_EXEC: begin
        tx_d = 8'h00; ld_d = 1'b0; sda_d = i2crs_pkg::SDA_KEEP; cv_d = 1'b0; cb_d = 8'h00;
        done_d = 1'b1;
        st_d = i2crs_pkg::ST_IDLE;
        case (op_q)
          i2crs_pkg::OP_START: begin
            ph_d = i2crs_pkg::PH_ADDRESS; eng_d = 1'b1;
          end
          i2crs_pkg::OP_POP: begin
            if (head_q != tail_q) begin
              tail_d = ring_next(tail_q); cv_d = 1'b1; cb_d = rg_rd;
            end
          end
          i2crs_pkg::OP_BYTE: begin
            if (eng_q) begin
              case (ph_q)
                i2crs_pkg::PH_ADDRESS: begin
                  if (byte_q[7:1] == cfg.dev_addr) begin
                    if (byte_q[0]) ph_d = i2crs_pkg::PH_ACK_TX;
                    else begin
                      dp_d = i2crs_pkg::DP_COMMAND; ph_d = i2crs_pkg::PH_ACK_RX;
                    end
                    sda_d = i2crs_pkg::SDA_DRIVE; tx_d = i2crs_pkg::ACK_CODE; ld_d = 1'b1;
                  end else eng_d = 1'b0;
                end
                i2crs_pkg::PH_ACK_RX: begin
                  ph_d = i2crs_pkg::PH_DATA_RX; sda_d = i2crs_pkg::SDA_RELEASE;
                end
                i2crs_pkg::PH_DATA_RX: begin
                  ph_d = i2crs_pkg::PH_ACK_RX; ld_d = 1'b1; sda_d = i2crs_pkg::SDA_DRIVE;
                  tx_d = i2crs_pkg::ACK_CODE;
                  case (dp_q)
                    i2crs_pkg::DP_COMMAND: begin
                      if (byte_q < cfg.first_cmd) begin
                        ptr_d = byte_q; dp_d = i2crs_pkg::DP_DATA;
                      end else if (byte_q == cfg.chk_code) dp_d = i2crs_pkg::DP_COUNT;
                      else begin
                        head_d = ring_next(head_q); rg_we = 1'b1;
                      end
                    end
                    i2crs_pkg::DP_DATA: begin
                      rf_we = wr_ok; ptr_d = ptr_q + 8'd1;
                    end
                    i2crs_pkg::DP_COUNT: begin
                      tgt_d = byte_q[BW-1:0]; sum_d = 8'h00; cnt_d = '0;
                      dp_d = i2crs_pkg::DP_ADDRESS;
                    end
                    i2crs_pkg::DP_ADDRESS: begin
                      ptr_d = byte_q; dp_d = i2crs_pkg::DP_CHECKED;
                    end
                    i2crs_pkg::DP_CHECKED: begin
                      if (cnt_q < tgt_q) begin
                        bf_we = 1'b1; sum_d = sum_q + byte_q; cnt_d = cnt_q + 1'b1;
                      end else if (byte_q == sum_q) begin
                        cnt_d = '0;
                        if (tgt_q != '0) begin
                          // Commit: each buffer entry is read, then written to the register file.
                          done_d = 1'b0; st_d = i2crs_pkg::ST_COMMIT_RD;
                        end
                      end else tx_d = i2crs_pkg::NAK_CODE;
                    end
                    default: ;
                  endcase
                end
                i2crs_pkg::PH_WAIT_ACK, i2crs_pkg::PH_ACK_TX: begin
                  if (ph_q == i2crs_pkg::PH_WAIT_ACK && byte_q[0]) eng_d = 1'b0;
                  else begin
                    ph_d = i2crs_pkg::PH_DATA_TX; sda_d = i2crs_pkg::SDA_DRIVE; ld_d = 1'b1;
                    tx_d = rdat;
                    if (dp_q == i2crs_pkg::DP_CHECKED) begin
                      if (cnt_q < tgt_q) begin
                        sum_d = sum_q + rdat; cnt_d = cnt_q + 1'b1; ptr_d = ptr_q + 8'd1;
                      end else tx_d = sum_q;
                    end else ptr_d = ptr_q + 8'd1;
                  end
                end
                i2crs_pkg::PH_DATA_TX: begin
                  ph_d = i2crs_pkg::PH_WAIT_ACK; sda_d = i2crs_pkg::SDA_RELEASE;
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
      i2crs_pkg::ST_COMMIT_RD: begin
        st_d = i2crs_pkg::ST_COMMIT_WR;
      end
      i2crs_pkg::ST_COMMIT_WR: begin
        rf_we = wr_ok; rf_wd = bf_rd;
        ptr_d = ptr_q + 8'd1; cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == tgt_q) begin
          done_d = 1'b1; st_d = i2crs_pkg::ST_IDLE;
        end else st_d = i2crs_pkg::ST_COMMIT_RD;
      end
      default: st_d = i2crs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= i2crs_pkg::ST_CLEAR; op_q <= '0; byte_q <= '0;
      ph_q <= i2crs_pkg::PH_ADDRESS; eng_q <= 1'b0; dp_q <= i2crs_pkg::DP_COMMAND;
      ptr_q <= '0; cnt_q <= '0; tgt_q <= '0; sum_q <= '0;
      head_q <= '0; tail_q <= '0; clr_q <= '0; done_q <= 1'b0;
      tx_q <= '0; cb_q <= '0; ld_q <= 1'b0; cv_q <= 1'b0; sda_q <= '0;
    end else begin
      st_q <= st_d; op_q <= op_d; byte_q <= byte_d;
      ph_q <= ph_d; eng_q <= eng_d; dp_q <= dp_d;
      ptr_q <= ptr_d; cnt_q <= cnt_d; tgt_q <= tgt_d; sum_q <= sum_d;
      head_q <= head_d; tail_q <= tail_d; clr_q <= clr_d; done_q <= done_d;
      tx_q <= tx_d; cb_q <= cb_d; ld_q <= ld_d; cv_q <= cv_d; sda_q <= sda_d;
    end
  end

  assign done_o           = done_q;
  assign tx_byte_o        = tx_q;
  assign tx_loaded_o      = ld_q;
  assign sda_mode_o       = sda_q;
  assign engaged_o        = eng_q;
  assign ack_phase_o      = eng_q && (ph_q == i2crs_pkg::PH_ACK_RX ||
                                      ph_q == i2crs_pkg::PH_WAIT_ACK);
  assign command_valid_o  = cv_q;
  assign command_byte_o   = cb_q;
  assign queue_nonempty_o = (head_q != tail_q);

  // A result never appears while the block is still working on an item.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // No byte is loaded without the SDA line being driven.
  a_tx_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && tx_loaded_o) |-> (sda_mode_o == i2crs_pkg::SDA_DRIVE))
    else $error("tx byte loaded while SDA not driven");

  // An accepted item raises busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

endmodule
